// File: hdl/mlfq_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
package mlfq_pkg;

    localparam int SLOTS      = 16;
    localparam int LEVELS     = 8;
    localparam int SLOT_W     = 4;
    localparam int LEVEL_W    = 3;
    localparam int COUNT_W    = 5;
    localparam int TIME_W     = 48;
    localparam int DELAY_W    = 24;
    localparam int QBASE_W    = 20;
    localparam int LIU_W      = 4;
    localparam int QUANT_W    = 27;
    localparam int FIFO_AW    = LEVEL_W + SLOT_W;
    localparam int FIFO_DEPTH = LEVELS * SLOTS;

    localparam logic [QBASE_W-1:0] QBASE_RESET = 20'd1000;
    localparam logic [LIU_W-1:0]   LIU_RESET   = 4'd4;

    // Request codes
    localparam logic [1:0] REQ_ADMIT    = 2'd0;
    localparam logic [1:0] REQ_DISPATCH = 2'd1;
    localparam logic [1:0] REQ_REPORT   = 2'd2;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_QBASE = 1'b0;
    localparam logic REG_LIU   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_IO_PICK,
        ST_IO_CMP,
        ST_POP_WAIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic fail;
        logic admit;
        logic io_pick;
        logic io_run;
        logic fifo_pop;
        logic pop_run;
        logic report;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] req;
        logic       any_free;
        logic       run_valid;
        logic       cand_any;
        logic       fifo_any;
        logic       io_ready;
    } t_stat;

endpackage

// File: hdl/mlfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/mlfq_ctrl.sv
// Controller state machine sequencing admit, dispatch and report requests.
module mlfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mlfq_pkg::t_stat i_stat,
    output mlfq_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    mlfq_pkg::t_state r_state;
    mlfq_pkg::t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlfq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            mlfq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = mlfq_pkg::ST_DECODE;
                end
            end
            mlfq_pkg::ST_DECODE: begin
                n_state = mlfq_pkg::ST_IDLE;
                unique case (i_stat.req)
                    mlfq_pkg::REQ_ADMIT: begin
                        if (i_stat.any_free) o_cmd.admit = 1'b1;
                        else                 o_cmd.fail  = 1'b1;
                    end
                    mlfq_pkg::REQ_DISPATCH: begin
                        if (i_stat.run_valid) o_cmd.fail = 1'b1;
                        else                  n_state    = mlfq_pkg::ST_IO_PICK;
                    end
                    mlfq_pkg::REQ_REPORT: begin
                        if (i_stat.run_valid) o_cmd.report = 1'b1;
                        else                  o_cmd.fail   = 1'b1;
                    end
                    default: o_cmd.fail = 1'b1;
                endcase
            end
            mlfq_pkg::ST_IO_PICK: begin
                if (i_stat.cand_any) begin
                    o_cmd.io_pick = 1'b1;
                    n_state       = mlfq_pkg::ST_IO_CMP;
                end else if (i_stat.fifo_any) begin
                    o_cmd.fifo_pop = 1'b1;
                    n_state        = mlfq_pkg::ST_POP_WAIT;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = mlfq_pkg::ST_IDLE;
                end
            end
            mlfq_pkg::ST_IO_CMP: begin
                if (i_stat.io_ready) begin
                    o_cmd.io_run = 1'b1;
                    n_state      = mlfq_pkg::ST_IDLE;
                end else begin
                    n_state = mlfq_pkg::ST_IO_PICK;
                end
            end
            mlfq_pkg::ST_POP_WAIT: begin
                o_cmd.pop_run = 1'b1;
                n_state       = mlfq_pkg::ST_IDLE;
            end
            default: n_state = mlfq_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != mlfq_pkg::ST_IDLE);
endmodule

// File: hdl/mlfq_dp.sv
// Datapath: slot table, level FIFOs, I/O finish times and configuration registers.
module mlfq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    input  logic [1:0]                          i_req_type,
    input  logic [mlfq_pkg::TIME_W-1:0]         i_now_time,
    input  logic                                i_finished,
    input  logic                                i_interrupted,
    input  logic [mlfq_pkg::DELAY_W-1:0]        i_io_delay,
    input  mlfq_pkg::t_cmd                      i_cmd,
    output mlfq_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    output logic                                o_status,
    output logic [mlfq_pkg::SLOT_W-1:0]         o_slot,
    output logic [mlfq_pkg::LEVEL_W-1:0]        o_level,
    output logic [mlfq_pkg::QUANT_W-1:0]        o_quantum
);
    localparam int SW = mlfq_pkg::SLOT_W;
    localparam int LW = mlfq_pkg::LEVEL_W;

    // Latched request
    logic [1:0]                    r_req;
    logic [mlfq_pkg::TIME_W-1:0]   r_now;
    logic                          r_fin;
    logic                          r_intr;
    logic [mlfq_pkg::DELAY_W-1:0]  r_delay;

    // Configuration
    logic [mlfq_pkg::QBASE_W-1:0]  r_qbase;
    logic [mlfq_pkg::LIU_W-1:0]    r_liu;

    // Scheduler state
    logic [mlfq_pkg::SLOTS-1:0]    r_used;
    logic [mlfq_pkg::SLOTS-1:0]    r_blocked;
    logic [LW-1:0]                 r_level [mlfq_pkg::SLOTS];
    logic [SW-1:0]                 r_head  [mlfq_pkg::LEVELS];
    logic [SW-1:0]                 r_tail  [mlfq_pkg::LEVELS];
    logic [mlfq_pkg::COUNT_W-1:0]  r_count [mlfq_pkg::LEVELS];
    logic                          r_run_valid;
    logic [SW-1:0]                 r_run_slot;
    logic [mlfq_pkg::SLOTS-1:0]    r_cand;
    logic [SW-1:0]                 r_sel;

    // Result registers
    logic                          r_valid;
    logic                          r_status;
    logic [SW-1:0]                 r_slot;
    logic [LW-1:0]                 r_olevel;
    logic [mlfq_pkg::QUANT_W-1:0]  r_quantum;

    logic                          free_any;
    logic [SW-1:0]                 free_slot;
    logic                          cand_any;
    logic [SW-1:0]                 cand_slot;
    logic                          fifo_any;
    logic [LW-1:0]                 fifo_lvl;
    logic [LW-1:0]                 bot;
    logic [SW-1:0]                 lvl_addr;
    logic [LW-1:0]                 cur_lvl;
    logic [LW:0]                   lvl_inc;
    logic [LW-1:0]                 dem_lvl;
    logic [mlfq_pkg::TIME_W:0]     sum;
    logic [mlfq_pkg::TIME_W-1:0]   io_time;
    logic                          push_rep;
    logic                          io_we;
    logic [mlfq_pkg::TIME_W-1:0]   io_rdata;
    logic [LW-1:0]                 push_lvl;
    logic                          fifo_we;
    logic [mlfq_pkg::FIFO_AW-1:0]  fifo_waddr;
    logic [SW-1:0]                 fifo_wdata;
    logic [mlfq_pkg::FIFO_AW-1:0]  fifo_raddr;
    logic [SW-1:0]                 fifo_rdata;
    logic                          cfg_we;

    // Find the lowest free slot
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = mlfq_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any  = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // Find the lowest blocked slot still to check
    always_comb begin
        cand_any  = 1'b0;
        cand_slot = '0;
        for (int i = mlfq_pkg::SLOTS - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                cand_any  = 1'b1;
                cand_slot = SW'(i);
            end
        end
    end

    // Find the highest-priority non-empty level
    always_comb begin
        fifo_any = 1'b0;
        fifo_lvl = '0;
        for (int i = mlfq_pkg::LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                fifo_any = 1'b1;
                fifo_lvl = LW'(i);
            end
        end
    end

    // Bottom level in use, clamped to the implemented levels
    always_comb begin
        if (r_liu == '0) begin
            bot = '0;
        end else if (r_liu > mlfq_pkg::LIU_W'(mlfq_pkg::LEVELS)) begin
            bot = LW'(mlfq_pkg::LEVELS - 1);
        end else begin
            bot = LW'(r_liu - 1'b1);
        end
    end

    // Level lookup and demotion
    assign lvl_addr = i_cmd.pop_run ? fifo_rdata : r_run_slot;
    assign cur_lvl  = r_level[lvl_addr];
    assign lvl_inc  = {1'b0, cur_lvl} + 1'b1;
    assign dem_lvl  = (lvl_inc > {1'b0, bot}) ? bot : lvl_inc[LW-1:0];

    // Saturated I/O finish time
    assign sum     = {1'b0, r_now} + {{(mlfq_pkg::TIME_W + 1 - mlfq_pkg::DELAY_W){1'b0}}, r_delay};
    assign io_time = sum[mlfq_pkg::TIME_W] ? '1 : sum[mlfq_pkg::TIME_W-1:0];

    assign push_rep = i_cmd.report && !r_fin && !r_intr;
    assign io_we    = i_cmd.report && !r_fin && r_intr;

    mlfq_ram #(
        .WIDTH (mlfq_pkg::TIME_W),
        .DEPTH (mlfq_pkg::SLOTS)
    ) u_io_ram (
        .i_clk   (i_clk),
        .i_we    (io_we),
        .i_waddr (r_run_slot),
        .i_wdata (io_time),
        .i_raddr (cand_slot),
        .o_rdata (io_rdata)
    );

    // Level FIFO write and read addresses
    assign push_lvl   = i_cmd.admit ? '0 : dem_lvl;
    assign fifo_waddr = {push_lvl, r_tail[push_lvl]};
    assign fifo_wdata = i_cmd.admit ? free_slot : r_run_slot;
    assign fifo_we    = (i_cmd.admit || push_rep)
                        && (r_count[push_lvl] < mlfq_pkg::COUNT_W'(mlfq_pkg::SLOTS));
    assign fifo_raddr = {fifo_lvl, r_head[fifo_lvl]};

    mlfq_ram #(
        .WIDTH (SW),
        .DEPTH (mlfq_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    // Configuration registers
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbase <= mlfq_pkg::QBASE_RESET;
            r_liu   <= mlfq_pkg::LIU_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == mlfq_pkg::REG_QBASE) begin
                r_qbase <= pwdata[mlfq_pkg::QBASE_W-1:0];
            end else begin
                r_liu <= pwdata[mlfq_pkg::LIU_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == mlfq_pkg::REG_LIU)
                    ? {{(32 - mlfq_pkg::LIU_W){1'b0}}, r_liu}
                    : {{(32 - mlfq_pkg::QBASE_W){1'b0}}, r_qbase};

    // Latch request fields on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= i_req_type;
            r_now   <= i_now_time;
            r_fin   <= i_finished;
            r_intr  <= i_interrupted;
            r_delay <= i_io_delay;
        end
        if (i_cmd.io_pick) begin
            r_sel <= cand_slot;
        end
    end

    // Update scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_blocked   <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_cand      <= '0;
            for (int i = 0; i < mlfq_pkg::SLOTS; i++) begin
                r_level[i] <= '0;
            end
            for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_cand <= r_used & r_blocked;
            end
            if (i_cmd.io_pick) begin
                r_cand[cand_slot] <= 1'b0;
            end
            if (fifo_we) begin
                r_tail[push_lvl]  <= r_tail[push_lvl] + 1'b1;
                r_count[push_lvl] <= r_count[push_lvl] + 1'b1;
            end
            if (i_cmd.admit) begin
                r_used[free_slot]    <= 1'b1;
                r_blocked[free_slot] <= 1'b0;
                r_level[free_slot]   <= '0;
            end
            if (i_cmd.io_run) begin
                r_blocked[r_sel] <= 1'b0;
                r_level[r_sel]   <= '0;
                r_run_valid      <= 1'b1;
                r_run_slot       <= r_sel;
            end
            if (i_cmd.fifo_pop) begin
                r_head[fifo_lvl]  <= r_head[fifo_lvl] + 1'b1;
                r_count[fifo_lvl] <= r_count[fifo_lvl] - 1'b1;
            end
            if (i_cmd.pop_run) begin
                r_run_valid <= 1'b1;
                r_run_slot  <= fifo_rdata;
            end
            if (i_cmd.report) begin
                r_run_valid <= 1'b0;
                if (r_fin) begin
                    r_used[r_run_slot]    <= 1'b0;
                    r_blocked[r_run_slot] <= 1'b0;
                    r_level[r_run_slot]   <= '0;
                end else if (r_intr) begin
                    r_blocked[r_run_slot] <= 1'b1;
                    r_level[r_run_slot]   <= '0;
                end else begin
                    r_level[r_run_slot] <= dem_lvl;
                end
            end
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fail || i_cmd.admit || i_cmd.io_run
                       || i_cmd.pop_run || i_cmd.report;
        end
        if (i_cmd.fail) begin
            r_status  <= mlfq_pkg::STATUS_NONE;
            r_slot    <= '0;
            r_olevel  <= '0;
            r_quantum <= '0;
        end else if (i_cmd.admit) begin
            r_status  <= mlfq_pkg::STATUS_OK;
            r_slot    <= free_slot;
            r_olevel  <= '0;
            r_quantum <= '0;
        end else if (i_cmd.io_run) begin
            r_status  <= mlfq_pkg::STATUS_OK;
            r_slot    <= r_sel;
            r_olevel  <= '0;
            r_quantum <= {{(mlfq_pkg::QUANT_W - mlfq_pkg::QBASE_W){1'b0}}, r_qbase};
        end else if (i_cmd.pop_run) begin
            r_status  <= mlfq_pkg::STATUS_OK;
            r_slot    <= fifo_rdata;
            r_olevel  <= cur_lvl;
            r_quantum <= {{(mlfq_pkg::QUANT_W - mlfq_pkg::QBASE_W){1'b0}}, r_qbase} << cur_lvl;
        end else if (i_cmd.report) begin
            r_status  <= mlfq_pkg::STATUS_OK;
            r_slot    <= r_run_slot;
            r_olevel  <= (r_fin || r_intr) ? '0 : dem_lvl;
            r_quantum <= '0;
        end else begin
            r_status  <= mlfq_pkg::STATUS_OK;
            r_slot    <= '0;
            r_olevel  <= '0;
            r_quantum <= '0;
        end
    end

    assign o_stat.req       = r_req;
    assign o_stat.any_free  = free_any;
    assign o_stat.run_valid = r_run_valid;
    assign o_stat.cand_any  = cand_any;
    assign o_stat.fifo_any  = fifo_any;
    assign o_stat.io_ready  = (r_now >= io_rdata);

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_slot    = r_slot;
    assign o_level   = r_olevel;
    assign o_quantum = r_quantum;
endmodule

// File: hdl/mlfq_scheduler_top.sv
// Top level of the multilevel feedback queue scheduler.
//
// Requests enter on start with req_type, now_time, finished, interrupted and
// io_delay; a beat is taken when start is high and busy is low. Every request
// yields one result beat on o_valid for a single cycle with status, slot,
// level and quantum; the receiver cannot hold it off.
// Admit, report and a dispatch refused while a task runs are answered from the
// decode state. Another dispatch first checks the blocked slots, lowest first,
// each with one read of the finish-time RAM and one compare against now_time;
// the first one found ready is run, else the head of the highest-priority
// non-empty level FIFO is popped and run, and if both are empty the dispatch
// is refused.
// busy falls in the cycle the result is shown, so a new request may be
// accepted then; one request is in work at a time.
// Configuration: APB port, quantum_base at 0x0 and levels_in_use at 0x4, to
// be written only while idle. pready is tied high.
// Reset (synchronous, active low) empties all slots and level FIFOs, clears
// the running task and restores quantum_base 1000 and levels_in_use 4.
module mlfq_scheduler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic [mlfq_pkg::TIME_W-1:0]         i_now_time,
    input  logic                                i_finished,
    input  logic                                i_interrupted,
    input  logic [mlfq_pkg::DELAY_W-1:0]        i_io_delay,
    output logic                                o_valid,
    output logic                                o_status,
    output logic [mlfq_pkg::SLOT_W-1:0]         o_slot,
    output logic [mlfq_pkg::LEVEL_W-1:0]        o_level,
    output logic [mlfq_pkg::QUANT_W-1:0]        o_quantum
);
    mlfq_pkg::t_cmd  cmd;
    mlfq_pkg::t_stat stat;

    assign pready = 1'b1;

    // Sequence requests
    mlfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold scheduler state and build results
    mlfq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .i_req_type    (i_req_type),
        .i_now_time    (i_now_time),
        .i_finished    (i_finished),
        .i_interrupted (i_interrupted),
        .i_io_delay    (i_io_delay),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_level       (o_level),
        .o_quantum     (o_quantum)
    );
endmodule

// File: hdl/mlfq_checker.sv
// Port-level checks for the scheduler, bound to the top level.
module mlfq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                pready,
    input logic                                o_valid,
    input logic                                o_status,
    input logic [mlfq_pkg::SLOT_W-1:0]         o_slot,
    input logic [mlfq_pkg::LEVEL_W-1:0]        o_level,
    input logic [mlfq_pkg::QUANT_W-1:0]        o_quantum
);
    // A result beat closes the request
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result beat while busy");

    // An accepted request occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

    // Result beats never come back to back
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("two result beats in a row");

    // Refused requests carry empty fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mlfq_pkg::STATUS_NONE)
        |-> (o_slot == '0 && o_level == '0 && o_quantum == '0))
        else $error("refused result with nonzero fields");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");
endmodule

bind mlfq_scheduler_top mlfq_checker u_mlfq_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .pready    (pready),
    .o_valid   (o_valid),
    .o_status  (o_status),
    .o_slot    (o_slot),
    .o_level   (o_level),
    .o_quantum (o_quantum)
);

// File: test/mlfq_scheduler_top_tb.sv
// Self-checking testbench for the multilevel feedback queue scheduler top level.
`timescale 1ns / 100ps

module mlfq_scheduler_top_tb;
    import mlfq_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_WAIT  = 60;

    typedef struct {
        logic [1:0]         req;
        logic [TIME_W-1:0]  now;
        logic               fin;
        logic               intr;
        logic [DELAY_W-1:0] dly;
        bit                 drain;
    } t_sched_req;

    typedef struct {
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [LEVEL_W-1:0] level;
        logic [QUANT_W-1:0] quantum;
    } t_sched_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    t_sched_req         cur_req = '{REQ_ADMIT, '0, 1'b0, 1'b0, '0, 1'b0};
    logic               o_valid;
    logic               o_status;
    logic [SLOT_W-1:0]  o_slot;
    logic [LEVEL_W-1:0] o_level;
    logic [QUANT_W-1:0] o_quantum;

    mlfq_scheduler_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_req_type   (cur_req.req),
        .i_now_time   (cur_req.now),
        .i_finished   (cur_req.fin),
        .i_interrupted(cur_req.intr),
        .i_io_delay   (cur_req.dly),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_level      (o_level),
        .o_quantum    (o_quantum)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the scheduler state
    logic [QBASE_W-1:0] qbase_cfg = QBASE_RESET;
    logic [LIU_W-1:0]   liu_cfg   = LIU_RESET;
    bit                 slot_busy [SLOTS];
    bit                 slot_wait_io [SLOTS];
    int                 slot_lvl [SLOTS];
    logic [TIME_W-1:0]  io_ready_at [SLOTS];
    int                 lq_store [LEVELS][SLOTS];
    int                 lq_head [LEVELS];
    int                 lq_tail [LEVELS];
    int                 lq_cnt [LEVELS];
    bit                 task_running = 1'b0;
    int                 task_slot = 0;

    t_sched_req req_backlog[$];
    t_sched_res expected_results[$];
    bit         failed = 1'b0;
    int         idle_cycles = 0;
    logic [TIME_W-1:0] sim_now = '0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 0;
            slot_wait_io[i] = 0;
            slot_lvl[i] = 0;
        end
        for (int l = 0; l < LEVELS; l++) begin
            lq_head[l] = 0;
            lq_tail[l] = 0;
            lq_cnt[l] = 0;
        end
    end

    function automatic void level_push(int lvl, int s);
        if (lq_cnt[lvl] < SLOTS) begin
            lq_store[lvl][lq_tail[lvl]] = s;
            lq_tail[lvl] = (lq_tail[lvl] + 1) % SLOTS;
            lq_cnt[lvl]++;
        end
    endfunction

    // Advance the shadow state by one request and return its result
    function automatic t_sched_res schedule(t_sched_req r);
        t_sched_res o;
        bit found;
        int s;
        int lv;
        int nlev;
        logic [TIME_W:0] t;
        o = '{STATUS_NONE, '0, '0, '0};
        found = 0;
        s = 0;
        case (r.req)
            REQ_ADMIT: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found = 1;
                        slot_busy[i] = 1;
                        slot_wait_io[i] = 0;
                        slot_lvl[i] = 0;
                        level_push(0, i);
                        o = '{STATUS_OK, SLOT_W'(i), '0, '0};
                    end
                end
            end
            REQ_DISPATCH: begin
                if (!task_running) begin
                    // I/O returns take precedence over the level FIFOs
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && slot_busy[i] && slot_wait_io[i]
                            && r.now >= io_ready_at[i]) begin
                            found = 1;
                            slot_wait_io[i] = 0;
                            slot_lvl[i] = 0;
                            s = i;
                        end
                    end
                    for (int l = 0; l < LEVELS; l++) begin
                        if (!found && lq_cnt[l] != 0) begin
                            found = 1;
                            s = lq_store[l][lq_head[l]];
                            lq_head[l] = (lq_head[l] + 1) % SLOTS;
                            lq_cnt[l]--;
                        end
                    end
                    if (found) begin
                        lv = slot_lvl[s];
                        task_running = 1;
                        task_slot = s;
                        o = '{STATUS_OK, SLOT_W'(s), LEVEL_W'(lv),
                              QUANT_W'({7'b0, qbase_cfg} << lv)};
                    end
                end
            end
            REQ_REPORT: begin
                if (task_running) begin
                    s = task_slot;
                    task_running = 0;
                    if (r.fin) begin
                        slot_busy[s] = 0;
                        slot_wait_io[s] = 0;
                        slot_lvl[s] = 0;
                    end else if (r.intr) begin
                        t = {1'b0, r.now} + r.dly;
                        if (t[TIME_W]) t = {1'b0, {TIME_W{1'b1}}};
                        slot_wait_io[s] = 1;
                        slot_lvl[s] = 0;
                        io_ready_at[s] = t[TIME_W-1:0];
                    end else begin
                        // Demote one level, clamped to the bottom level in use
                        nlev = (liu_cfg == 0) ? 1 : ((liu_cfg > LEVELS) ? LEVELS : liu_cfg);
                        lv = slot_lvl[s] + 1;
                        if (lv > nlev - 1) lv = nlev - 1;
                        slot_lvl[s] = lv;
                        level_push(lv, s);
                    end
                    o = '{STATUS_OK, SLOT_W'(s), LEVEL_W'(slot_lvl[s]), '0};
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Driver: bursts of beats separated by random gaps
    int burst_left = 8;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(schedule(cur_req));
                if (--burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (req_backlog.size() > 0
                             && (!req_backlog[0].drain || expected_results.size() == 0)) begin
                    cur_req <= req_backlog.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_sched_res exp_res;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: slot %0d", o_slot);
                    failed = 1'b1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        failed = 1'b1;
                    end
                    if (o_slot !== exp_res.slot) begin
                        $error("slot: expected %0d, got %0d", exp_res.slot, o_slot);
                        failed = 1'b1;
                    end
                    if (o_level !== exp_res.level) begin
                        $error("level: expected %0d, got %0d", exp_res.level, o_level);
                        failed = 1'b1;
                    end
                    if (o_quantum !== exp_res.quantum) begin
                        $error("quantum: expected %0d, got %0d",
                               exp_res.quantum, o_quantum);
                        failed = 1'b1;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic add_req(logic [1:0] req, logic [TIME_W-1:0] now, logic fin,
                           logic intr, logic [DELAY_W-1:0] dly);
        req_backlog.push_back('{req, now, fin, intr, dly, 1'b0});
    endtask

    // Write one register over the APB port
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0) qbase_cfg = data[QBASE_W-1:0];
        else liu_cfg = data[LIU_W-1:0];
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || start || expected_results.size() != 0);
    endtask

    // Mostly admit / dispatch / report traffic on a rising clock, some noise
    task automatic add_random(int n);
        int pick;
        logic [TIME_W-1:0] now;
        logic [DELAY_W-1:0] dly;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            sim_now = sim_now + $urandom_range(0, 4000);
            now = sim_now;
            if ($urandom_range(0, 29) == 0) now = TIME_W'({$urandom, $urandom});
            dly = ($urandom_range(0, 19) == 0) ? DELAY_W'($urandom)
                                                : DELAY_W'($urandom_range(0, 20000));
            add_req(pick < 25 ? REQ_ADMIT : pick < 60 ? REQ_DISPATCH :
                    pick < 96 ? REQ_REPORT : 2'd3,
                    now, $urandom_range(0, 9) < 3, $urandom_range(0, 9) < 3, dly);
            if ($urandom_range(0, 99) == 0) req_backlog[req_backlog.size()-1].drain = 1'b1;
        end
        req_backlog[req_backlog.size()-n].drain = 1'b1;
    endtask

    initial begin
        logic [TIME_W-1:0] tmax;
        tmax = {TIME_W{1'b1}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, full table, demotion, I/O park and return
        add_req(REQ_DISPATCH, 0, 0, 0, 0);
        add_req(REQ_REPORT, 0, 1, 0, 0);
        add_req(2'd3, tmax, 1, 1, '1);
        for (int i = 0; i < 17; i++) add_req(REQ_ADMIT, 0, 0, 0, 0);
        add_req(REQ_DISPATCH, 100, 0, 0, 0);
        add_req(REQ_DISPATCH, 100, 0, 0, 0);
        add_req(REQ_REPORT, 100, 0, 0, 0);
        add_req(REQ_DISPATCH, 100, 0, 0, 0);
        add_req(REQ_REPORT, tmax - 5, 0, 1, '1);
        add_req(REQ_DISPATCH, 100, 0, 0, 0);
        add_req(REQ_REPORT, 200, 1, 1, 7);
        add_req(REQ_DISPATCH, tmax, 0, 0, 0);
        add_req(REQ_REPORT, 300, 0, 0, 0);
        wait_drained();

        reg_write(3'd0, 32'd1);
        reg_write(3'd4, 32'd1);
        add_random(150);
        wait_drained();
        reg_write(3'd0, 32'hFFFFF);
        reg_write(3'd4, 32'd8);
        add_random(170);
        wait_drained();
        reg_write(3'd0, 32'd777);
        reg_write(3'd4, 32'd0);
        add_random(150);
        wait_drained();
        reg_write(3'd0, 32'd12345);
        reg_write(3'd4, 32'd15);
        add_random(150);
        wait_drained();
        reg_write(3'd0, $urandom_range(1, 32'hFFFFF));
        reg_write(3'd4, $urandom_range(1, 8));
        add_random(150);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (!failed && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
